@@ rtl/bfiq_pkg.sv @@
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types and constants of the Bloom filter insert and query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

   localparam int unsigned MAX_BITS   = 65536;
   localparam int unsigned WORD_COUNT = MAX_BITS / 64;
   localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);
   localparam int unsigned POS_W      = $clog2(MAX_BITS);
   localparam int unsigned M_W        = 17;
   localparam int unsigned K_W        = 5;
   localparam int unsigned CSR_W      = 17;

   localparam logic [63:0] GOLDEN  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] GOLDEN2 = 64'h3c6ef372fe94f82a;
   localparam logic [63:0] MUL_C1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_C2  = 64'h94d049bb133111eb;

   localparam logic [M_W-1:0] BITS_MAX   = M_W'(MAX_BITS);
   localparam logic [K_W-1:0] HASH_LIMIT = 5'd24;

   localparam logic [3:0]        MIX_LAST = 4'd8;
   localparam logic [6:0]        MOD_LAST = 7'd64;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(WORD_COUNT - 1);

   localparam logic CSR_BIT_COUNT  = 1'b0;
   localparam logic CSR_HASH_COUNT = 1'b1;

   localparam logic ACT_INSERT = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MIX, ST_MOD, ST_RD, ST_UPD, ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_A, PH_B, PH_IDX, PH_FIN
   } phase_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_LOAD, OP_M0, OP_M1, OP_M2, OP_X27, OP_X31,
      OP_MODI, OP_MODS, OP_RD, OP_SET, OP_TEST, OP_CLR
   } op_type;

   typedef enum logic [1:0] {
      HOP_NONE, HOP_SET, HOP_XOR
   } hop_type;

   typedef struct packed {
      op_type              op;
      phase_type           src;
      hop_type             hop;
      logic                csel;
      logic [ADDR_W-1:0]   clr_addr;
   } cmd_type;

   typedef struct packed {
      logic [K_W-1:0] k_eff;
      logic           action;
      logic           bit_val;
   } status_type;

endpackage

@@ rtl/bloom_filter_insert_query.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter over pairs of 64-bit keys with insert and membership query.
//
//   channel  dir  beat
//   req_     in   action, key_first, key_second
//   rsp_     out  maybe_present (queries only)
//   csr_     in   register write (bit_count, hash_count)
//
// One item at a time on one 32x32 multiplier. The first hash mixes both key
// halves, the hash index and a final round, later hashes only the index and
// the final round; each hash then runs a bit-serial modulo and a read and an
// update of the word store. An insert returns to ready after its last hash; a
// query ends in a response (queries stop at the first clear bit). After reset
// all 1024 words of the store are cleared before the first beat is taken. A
// pending response holds the block until taken.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic signed [63:0]          req_key_first,
   input  logic signed [63:0]          req_key_second,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_maybe_present,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [bfiq_pkg::CSR_W-1:0]  csr_wdata
);

   bfiq_pkg::cmd_type    cmd;
   bfiq_pkg::status_type status;

   bfiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfiq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_key_first     (req_key_first),
      .req_key_second    (req_key_second),
      .rsp_maybe_present (rsp_maybe_present),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accept");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");

endmodule

@@ rtl/bfiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfiq_ctrl
// Sequencer: store clear, hash mixing steps, modulo steps, bit update/test, response.
// ----------------------------------------------------------------------------
module bfiq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bfiq_pkg::status_type  status,
   output bfiq_pkg::cmd_type     cmd
);

   bfiq_pkg::state_type         state_ff, state_in;
   bfiq_pkg::phase_type         phase_ff, phase_in;
   logic [3:0]                  step_ff, step_in;
   logic [6:0]                  cnt_ff, cnt_in;
   logic [4:0]                  idx_ff, idx_in;
   logic [bfiq_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic                        last_hash;

   assign last_hash = (idx_ff == status.k_eff - 5'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfiq_pkg::ST_CLEAR;
         phase_ff <= bfiq_pkg::PH_A;
         step_ff  <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         bfiq_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == bfiq_pkg::CLR_LAST) state_in = bfiq_pkg::ST_IDLE;
         end
         bfiq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bfiq_pkg::ST_MIX;
               phase_in = bfiq_pkg::PH_A;
               step_in  = '0;
               idx_in   = '0;
            end
         end
         bfiq_pkg::ST_MIX: begin
            if (step_ff == bfiq_pkg::MIX_LAST) begin
               step_in = '0;
               unique case (phase_ff)
                  bfiq_pkg::PH_A:   phase_in = bfiq_pkg::PH_B;
                  bfiq_pkg::PH_B:   phase_in = bfiq_pkg::PH_IDX;
                  bfiq_pkg::PH_IDX: phase_in = bfiq_pkg::PH_FIN;
                  default: begin
                     state_in = bfiq_pkg::ST_MOD;
                     cnt_in   = '0;
                  end
               endcase
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         bfiq_pkg::ST_MOD: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == bfiq_pkg::MOD_LAST) state_in = bfiq_pkg::ST_RD;
         end
         bfiq_pkg::ST_RD: state_in = bfiq_pkg::ST_UPD;
         bfiq_pkg::ST_UPD: begin
            if (status.action != bfiq_pkg::ACT_INSERT && !status.bit_val) begin
               state_in = bfiq_pkg::ST_RESP;
            end else if (last_hash) begin
               state_in = (status.action == bfiq_pkg::ACT_INSERT) ?
                          bfiq_pkg::ST_IDLE : bfiq_pkg::ST_RESP;
            end else begin
               state_in = bfiq_pkg::ST_MIX;
               phase_in = bfiq_pkg::PH_IDX;
               step_in  = '0;
               idx_in   = idx_ff + 5'd1;
            end
         end
         bfiq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = bfiq_pkg::ST_IDLE;
         end
         default: state_in = bfiq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.op       = bfiq_pkg::OP_NONE;
      cmd.src      = phase_ff;
      cmd.hop      = bfiq_pkg::HOP_NONE;
      cmd.csel     = 1'b0;
      cmd.clr_addr = clr_ff;
      unique case (state_ff)
         bfiq_pkg::ST_CLEAR: cmd.op = bfiq_pkg::OP_CLR;
         bfiq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = bfiq_pkg::OP_ACCEPT;
         end
         bfiq_pkg::ST_MIX: begin
            cmd.csel = (step_ff > 4'd4);
            unique case (step_ff)
               4'd0: begin
                  cmd.op = bfiq_pkg::OP_LOAD;
                  if (phase_ff == bfiq_pkg::PH_B) cmd.hop = bfiq_pkg::HOP_SET;
                  else if (phase_ff == bfiq_pkg::PH_IDX && idx_ff == 5'd0)
                     cmd.hop = bfiq_pkg::HOP_XOR;
               end
               4'd1, 4'd5: cmd.op = bfiq_pkg::OP_M0;
               4'd2, 4'd6: cmd.op = bfiq_pkg::OP_M1;
               4'd3, 4'd7: cmd.op = bfiq_pkg::OP_M2;
               4'd4:       cmd.op = bfiq_pkg::OP_X27;
               4'd8:       cmd.op = bfiq_pkg::OP_X31;
               default:    cmd.op = bfiq_pkg::OP_NONE;
            endcase
         end
         bfiq_pkg::ST_MOD:
            cmd.op = (cnt_ff == 7'd0) ? bfiq_pkg::OP_MODI : bfiq_pkg::OP_MODS;
         bfiq_pkg::ST_RD: cmd.op = bfiq_pkg::OP_RD;
         bfiq_pkg::ST_UPD:
            cmd.op = (status.action == bfiq_pkg::ACT_INSERT) ?
                     bfiq_pkg::OP_SET : bfiq_pkg::OP_TEST;
         bfiq_pkg::ST_RESP: rsp_valid = 1'b1;
         default: cmd.op = bfiq_pkg::OP_NONE;
      endcase
   end

endmodule

@@ rtl/bfiq_dp.sv @@
// ----------------------------------------------------------------------------
// bfiq_dp
// Datapath: config registers, splitmix64 unit with a shared 32x32
// multiplier, bit-serial modulo, and the filter word store.
// ----------------------------------------------------------------------------
module bfiq_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  bfiq_pkg::cmd_type           cmd,
   output bfiq_pkg::status_type        status,
   input  logic                        req_action,
   input  logic signed [63:0]          req_key_first,
   input  logic signed [63:0]          req_key_second,
   output logic                        rsp_maybe_present,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [bfiq_pkg::CSR_W-1:0]  csr_wdata
);

   logic [bfiq_pkg::M_W-1:0] m_ff;
   logic [bfiq_pkg::K_W-1:0] k_ff;
   logic [bfiq_pkg::M_W-1:0] m_eff;
   logic [bfiq_pkg::K_W-1:0] k_eff;
   logic                     action_ff;
   logic [63:0]              a_ff, b_ff, idxg_ff, v_ff, acc_ff, hacc_ff;
   logic [63:0]              v_in, acc_in, src_val, t_val, cst;
   logic [31:0]              mul_a, mul_b;
   logic [63:0]              prod;
   logic [bfiq_pkg::M_W-1:0] rem_ff;
   logic [bfiq_pkg::M_W:0]   rem_sh;
   logic [bfiq_pkg::M_W-1:0] rem_in;
   logic [63:0]              rdata_ff;
   logic                     present_ff;
   logic [63:0]              mem [bfiq_pkg::WORD_COUNT];
   logic [bfiq_pkg::ADDR_W-1:0] waddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= bfiq_pkg::BITS_MAX;
         k_ff <= 5'd7;
      end else if (csr_we) begin
         if (csr_index == bfiq_pkg::CSR_BIT_COUNT) m_ff <= csr_wdata;
         else k_ff <= csr_wdata[bfiq_pkg::K_W-1:0];
      end
   end

   always_comb begin
      m_eff = m_ff;
      if (m_ff == '0) m_eff = 17'd1;
      else if (m_ff > bfiq_pkg::BITS_MAX) m_eff = bfiq_pkg::BITS_MAX;
      k_eff = k_ff;
      if (k_ff == '0) k_eff = 5'd1;
      else if (k_ff > bfiq_pkg::HASH_LIMIT) k_eff = bfiq_pkg::HASH_LIMIT;
   end

   always_comb begin
      case (cmd.src)
         bfiq_pkg::PH_A:   src_val = a_ff + bfiq_pkg::GOLDEN;
         bfiq_pkg::PH_B:   src_val = b_ff + bfiq_pkg::GOLDEN2;
         bfiq_pkg::PH_IDX: src_val = idxg_ff + bfiq_pkg::GOLDEN;
         default:          src_val = (hacc_ff ^ v_ff) + bfiq_pkg::GOLDEN;
      endcase
      t_val = src_val ^ (src_val >> 30);
      cst   = cmd.csel ? bfiq_pkg::MUL_C2 : bfiq_pkg::MUL_C1;
      mul_a = (cmd.op == bfiq_pkg::OP_M2) ? v_ff[63:32] : v_ff[31:0];
      mul_b = (cmd.op == bfiq_pkg::OP_M1) ? cst[63:32] : cst[31:0];
      prod  = {32'd0, mul_a} * {32'd0, mul_b};
      rem_sh = {rem_ff, v_ff[63]};
      rem_in = (rem_sh >= {1'b0, m_eff}) ? bfiq_pkg::M_W'(rem_sh - {1'b0, m_eff})
                                         : rem_sh[bfiq_pkg::M_W-1:0];
      v_in   = v_ff;
      acc_in = acc_ff;
      case (cmd.op)
         bfiq_pkg::OP_LOAD: v_in = t_val;
         bfiq_pkg::OP_M0:   acc_in = prod;
         bfiq_pkg::OP_M1, bfiq_pkg::OP_M2:
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         bfiq_pkg::OP_X27:  v_in = acc_ff ^ (acc_ff >> 27);
         bfiq_pkg::OP_X31:  v_in = acc_ff ^ (acc_ff >> 31);
         bfiq_pkg::OP_MODS: v_in = {v_ff[62:0], 1'b0};
         default: ;
      endcase
   end

   assign waddr  = rem_ff[bfiq_pkg::POS_W-1:6];
   assign status = '{k_eff: k_eff, action: action_ff, bit_val: rdata_ff[rem_ff[5:0]]};
   assign rsp_maybe_present = present_ff;

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      acc_ff <= acc_in;
      if (cmd.op == bfiq_pkg::OP_ACCEPT) begin
         a_ff      <= req_key_first;
         b_ff      <= req_key_second;
         action_ff <= req_action;
         idxg_ff   <= '0;
      end
      if (cmd.op == bfiq_pkg::OP_SET || cmd.op == bfiq_pkg::OP_TEST)
         idxg_ff <= idxg_ff + bfiq_pkg::GOLDEN;
      if (cmd.op == bfiq_pkg::OP_LOAD) begin
         case (cmd.hop)
            bfiq_pkg::HOP_SET: hacc_ff <= v_ff;
            bfiq_pkg::HOP_XOR: hacc_ff <= hacc_ff ^ v_ff;
            default: ;
         endcase
      end
      if (cmd.op == bfiq_pkg::OP_MODI) rem_ff <= '0;
      else if (cmd.op == bfiq_pkg::OP_MODS) rem_ff <= rem_in;
      if (cmd.op == bfiq_pkg::OP_TEST) present_ff <= status.bit_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == bfiq_pkg::OP_RD) rdata_ff <= mem[waddr];
      if (cmd.op == bfiq_pkg::OP_CLR) mem[cmd.clr_addr] <= '0;
      else if (cmd.op == bfiq_pkg::OP_SET)
         mem[waddr] <= rdata_ff | (64'd1 << rem_ff[5:0]);
   end

endmodule
